>>> rtl/servo_homing_sequencer_assert.svh
// ----------------------------------------------------------------------------
// Servo homing sequencer assertion macros
// Shorthand for the concurrent checks on the block's ports. Every macro
// expects signals named clk and arst_n in the scope where it is used.
// ----------------------------------------------------------------------------
`ifndef SERVO_HOMING_SEQUENCER_ASSERT_SVH
`define SERVO_HOMING_SEQUENCER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HSQ_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define HSQ_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/hsq_pkg.sv
// ----------------------------------------------------------------------------
// Servo homing sequencer package
// Beat payload types, command, step, status, method and quick stop codes,
// and the configuration register set shared by the sequencer modules.
// ----------------------------------------------------------------------------
package hsq_pkg;

	// Drive command codes; the reserved code behaves as disable.
	localparam logic [1:0] CMD_DISABLE  = 2'd0;
	localparam logic [1:0] CMD_ENABLE   = 2'd1;
	localparam logic [1:0] CMD_EBRAKE   = 2'd2;
	localparam logic [1:0] CMD_RESERVED = 2'd3;

	// Homing method codes that the drive supports.
	localparam logic [6:0] HM_NONE         = 7'd0;
	localparam logic [6:0] HM_SWITCH_INDEX = 7'd7;
	localparam logic [6:0] HM_AT_POSITION  = 7'd35;

	// Quick stop option codes of the drive profile.
	localparam logic [3:0] QSO_DISABLE       = 4'd0;
	localparam logic [3:0] QSO_SLOW_DOWN     = 4'd1;
	localparam logic [3:0] QSO_QUICK         = 4'd2;
	localparam logic [3:0] QSO_CURRENT       = 4'd3;
	localparam logic [3:0] QSO_VOLTAGE       = 4'd4;
	localparam logic [3:0] QSO_SLOW_STAY     = 4'd5;
	localparam logic [3:0] QSO_QUICK_STAY    = 4'd6;
	localparam logic [3:0] QSO_CURRENT_STAY  = 4'd7;
	localparam logic [3:0] QSO_VOLTAGE_STAY  = 4'd8;

	// Homing steps.
	typedef enum logic [3:0] {
		STEP_INIT      = 4'd0,
		STEP_START     = 4'd1,
		STEP_SEEK_SW   = 4'd2,
		STEP_SEEK_HOME = 4'd3,
		STEP_RETRACT   = 4'd4,
		STEP_SEEK_IDX  = 4'd5,
		STEP_DECEL     = 4'd6,
		STEP_DONE      = 4'd7,
		STEP_FAIL      = 4'd8
	} step_t;

	// Homing status.
	typedef enum logic [1:0] {
		HS_IDLE = 2'd0,
		HS_OK   = 2'd1,
		HS_FAIL = 2'd2
	} hstat_t;

	// Configuration register indexes.
	typedef enum logic [2:0] {
		CFG_HOME_MODE      = 3'd0,
		CFG_SWITCH_SPEED   = 3'd1,
		CFG_INDEX_SPEED    = 3'd2,
		CFG_HOMING_ACCEL   = 3'd3,
		CFG_QS_DECEL       = 3'd4,
		CFG_PROFILE_DECEL  = 3'd5,
		CFG_QS_OPTION      = 3'd6,
		CFG_HOME_OFFSET    = 3'd7
	} cfg_idx_t;

	localparam int CFG_DATA_W = 32;

	// Configuration register set.
	typedef struct packed {
		logic [6:0]         home_mode;
		logic [30:0]        switch_search_speed;
		logic [30:0]        index_search_speed;
		logic [30:0]        homing_accel;
		logic [30:0]        quick_stop_decel;
		logic [30:0]        profile_decel;
		logic [3:0]         quick_stop_option;
		logic signed [31:0] home_offset;
	} cfg_t;

	// One control tick.
	typedef struct packed {
		logic [1:0]         drive_command;
		logic               emergency_requested;
		logic               halt;
		logic               brake_released;
		logic               positive_limit;
		logic               negative_limit;
		logic               home_sensor;
		logic               index_pulse;
		logic               standstill;
		logic signed [31:0] actual_position;
	} tick_t;

	// One result of a control tick.
	typedef struct packed {
		logic signed [31:0] target_speed;
		logic [30:0]        target_accel;
		logic [3:0]         homing_step;
		logic [1:0]         homing_status;
		logic               offset_valid;
		logic signed [31:0] home_position;
		logic               force_disable;
		logic               planner_active;
		logic               planner_restart;
	} result_t;

endpackage

>>> rtl/hsq_channels.sv
// ----------------------------------------------------------------------------
// Servo homing sequencer channels
// Valid/ready channels for control ticks and for results.
// ----------------------------------------------------------------------------
interface hsq_tick_if;
	logic          valid;
	logic          ready;
	hsq_pkg::tick_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface hsq_result_if;
	logic             valid;
	logic             ready;
	hsq_pkg::result_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> rtl/hsq_cfg_regs.sv
// ----------------------------------------------------------------------------
// Servo homing sequencer configuration registers
// Write-only register file loaded through a plain write port.
// ----------------------------------------------------------------------------
module hsq_cfg_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            wr_en,
	input  logic [2:0]                      wr_index,
	input  logic [hsq_pkg::CFG_DATA_W-1:0]  wr_data,
	output hsq_pkg::cfg_t                   cfg
);

	hsq_pkg::cfg_t cfg_q;

	// Decode the index and load the addressed register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			unique case (hsq_pkg::cfg_idx_t'(wr_index))
				hsq_pkg::CFG_HOME_MODE:     cfg_q.home_mode           <= wr_data[6:0];
				hsq_pkg::CFG_SWITCH_SPEED:  cfg_q.switch_search_speed <= wr_data[30:0];
				hsq_pkg::CFG_INDEX_SPEED:   cfg_q.index_search_speed  <= wr_data[30:0];
				hsq_pkg::CFG_HOMING_ACCEL:  cfg_q.homing_accel        <= wr_data[30:0];
				hsq_pkg::CFG_QS_DECEL:      cfg_q.quick_stop_decel    <= wr_data[30:0];
				hsq_pkg::CFG_PROFILE_DECEL: cfg_q.profile_decel       <= wr_data[30:0];
				hsq_pkg::CFG_QS_OPTION:     cfg_q.quick_stop_option   <= wr_data[3:0];
				hsq_pkg::CFG_HOME_OFFSET:   cfg_q.home_offset         <= signed'(wr_data);
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> rtl/hsq_step_unit.sv
// ----------------------------------------------------------------------------
// Servo homing sequencer step unit
// Holds the homing state and works out one tick's result and next state.
// ----------------------------------------------------------------------------
module hsq_step_unit (
	input  logic             clk,
	input  logic             arst_n,
	input  hsq_pkg::cfg_t    cfg,
	input  logic             fire,
	input  hsq_pkg::tick_t   tick,
	output hsq_pkg::result_t res
);

	// Method latched at the enable edge.
	typedef enum logic [1:0] {
		METH_NONE,
		METH_SWITCH_INDEX,
		METH_AT_POSITION
	} meth_t;

	logic [1:0]         prev_cmd_q, prev_cmd_d;
	hsq_pkg::step_t     step_q, step_d;
	logic signed [31:0] speed_q, speed_d;
	logic [30:0]        accel_q, accel_d;
	hsq_pkg::hstat_t    status_q, status_d;
	logic               idx_latch_q, idx_latch_d;
	meth_t              meth_q, meth_d;
	logic [30:0]        sw_spd_q, sw_spd_d;
	logic [30:0]        idx_spd_q, idx_spd_d;

	logic [1:0]         cmd;
	logic               early;
	logic               idx_seen;
	logic               fdis;
	logic               prst;
	logic               offv;
	logic signed [31:0] homep;
	logic signed [31:0] sw_neg;
	logic signed [31:0] idx_neg;

	// Next state and result of the current tick.
	always_comb begin
		prev_cmd_d  = prev_cmd_q;
		step_d      = step_q;
		speed_d     = speed_q;
		accel_d     = accel_q;
		status_d    = status_q;
		idx_latch_d = idx_latch_q;
		meth_d      = meth_q;
		sw_spd_d    = sw_spd_q;
		idx_spd_d   = idx_spd_q;
		sw_neg      = 32'sd0 - signed'({1'b0, sw_spd_q});
		idx_neg     = 32'sd0 - signed'({1'b0, idx_spd_q});
		early       = 1'b0;
		idx_seen    = 1'b0;
		fdis        = 1'b0;
		prst        = 1'b0;
		offv        = 1'b0;
		homep       = '0;
		cmd         = (tick.drive_command == hsq_pkg::CMD_RESERVED) ?
			hsq_pkg::CMD_DISABLE : tick.drive_command;

		if (cmd == hsq_pkg::CMD_ENABLE) begin
			if (!tick.emergency_requested) begin
				// Enable edge: latch the method and restart the sequence.
				if (prev_cmd_q == hsq_pkg::CMD_DISABLE) begin
					case (cfg.home_mode)
						hsq_pkg::HM_NONE:         meth_d = METH_NONE;
						hsq_pkg::HM_SWITCH_INDEX: meth_d = METH_SWITCH_INDEX;
						hsq_pkg::HM_AT_POSITION:  meth_d = METH_AT_POSITION;
						default: begin
							meth_d = METH_NONE;
							early  = 1'b1;
						end
					endcase
					if (early) begin
						step_d = hsq_pkg::STEP_FAIL;
						fdis   = 1'b1;
					end else begin
						step_d      = hsq_pkg::STEP_START;
						sw_spd_d    = cfg.switch_search_speed;
						idx_spd_d   = cfg.index_search_speed;
						sw_neg      = 32'sd0 - signed'({1'b0, cfg.switch_search_speed});
						idx_neg     = 32'sd0 - signed'({1'b0, cfg.index_search_speed});
						accel_d     = cfg.homing_accel;
						idx_latch_d = 1'b0;
						status_d    = hsq_pkg::HS_IDLE;
						prst        = 1'b1;
					end
				end

				if (!early) begin
					idx_latch_d = idx_latch_d | tick.index_pulse;
					if (tick.halt || !tick.brake_released) begin
						speed_d = '0;
					end else if (step_d != hsq_pkg::STEP_DONE) begin
						idx_seen    = idx_latch_d;
						idx_latch_d = 1'b0;
						case (meth_d)
							METH_SWITCH_INDEX: begin
								// Switch search, retract and index search.
								case (step_d)
									hsq_pkg::STEP_INIT: ;
									hsq_pkg::STEP_START: begin
										if (tick.positive_limit && !tick.home_sensor) begin
											speed_d = sw_neg;
											step_d  = hsq_pkg::STEP_SEEK_HOME;
										end else if (tick.home_sensor) begin
											speed_d = sw_neg;
											step_d  = hsq_pkg::STEP_RETRACT;
										end else begin
											speed_d = signed'({1'b0, sw_spd_d});
											step_d  = hsq_pkg::STEP_SEEK_SW;
										end
									end
									hsq_pkg::STEP_SEEK_SW: begin
										if (tick.home_sensor) begin
											speed_d = sw_neg;
											step_d  = hsq_pkg::STEP_RETRACT;
										end else if (tick.positive_limit) begin
											speed_d = sw_neg;
											step_d  = hsq_pkg::STEP_SEEK_HOME;
										end else if (tick.negative_limit) begin
											speed_d = '0;
											step_d  = hsq_pkg::STEP_FAIL;
										end
									end
									hsq_pkg::STEP_SEEK_HOME: begin
										if (tick.home_sensor) begin
											speed_d = sw_neg;
											step_d  = hsq_pkg::STEP_RETRACT;
										end else if (tick.negative_limit) begin
											speed_d = '0;
											step_d  = hsq_pkg::STEP_FAIL;
										end
									end
									hsq_pkg::STEP_RETRACT: begin
										if (!tick.home_sensor) begin
											speed_d = idx_neg;
											step_d  = hsq_pkg::STEP_SEEK_IDX;
										end
									end
									hsq_pkg::STEP_SEEK_IDX: begin
										if (idx_seen) begin
											speed_d = '0;
											step_d  = hsq_pkg::STEP_DECEL;
										end
									end
									hsq_pkg::STEP_DECEL: begin
										if (tick.standstill) begin
											speed_d = '0;
											step_d  = hsq_pkg::STEP_DONE;
										end
									end
									hsq_pkg::STEP_DONE: speed_d = '0;
									default: begin
										speed_d = '0;
										step_d  = hsq_pkg::STEP_FAIL;
									end
								endcase
							end
							METH_AT_POSITION: begin
								speed_d = '0;
								step_d  = hsq_pkg::STEP_DONE;
							end
							default: step_d = hsq_pkg::STEP_FAIL;
						endcase
					end

					// Status and the one-shot home position.
					if (step_d == hsq_pkg::STEP_DONE && status_d != hsq_pkg::HS_OK) begin
						status_d = hsq_pkg::HS_OK;
						offv     = 1'b1;
						homep    = tick.actual_position + cfg.home_offset;
					end else if (step_d == hsq_pkg::STEP_FAIL) begin
						status_d = hsq_pkg::HS_FAIL;
					end
				end
			end else begin
				idx_latch_d = idx_latch_d | tick.index_pulse;
				cmd         = hsq_pkg::CMD_DISABLE;
				fdis        = 1'b1;
			end
		end else begin
			idx_latch_d = idx_latch_d | tick.index_pulse;
		end

		// Emergency brake and command tracking.
		if (!early) begin
			if (cmd == hsq_pkg::CMD_EBRAKE) begin
				step_d  = hsq_pkg::STEP_FAIL;
				speed_d = '0;
				case (cfg.quick_stop_option) inside
					hsq_pkg::QSO_QUICK, hsq_pkg::QSO_CURRENT,
					hsq_pkg::QSO_QUICK_STAY, hsq_pkg::QSO_CURRENT_STAY:
						accel_d = cfg.quick_stop_decel;
					hsq_pkg::QSO_DISABLE: ;
					default: accel_d = cfg.profile_decel;
				endcase
				if (cfg.quick_stop_option <= hsq_pkg::QSO_VOLTAGE &&
					(cfg.quick_stop_option == hsq_pkg::QSO_DISABLE || tick.standstill)) begin
					fdis = 1'b1;
					cmd  = hsq_pkg::CMD_DISABLE;
				end
			end
			prev_cmd_d = cmd;
		end
	end

	// Result of the tick.
	always_comb begin
		res.target_speed    = speed_d;
		res.target_accel    = accel_d;
		res.homing_step     = step_d;
		res.homing_status   = status_d;
		res.offset_valid    = offv;
		res.home_position   = homep;
		res.force_disable   = fdis;
		res.planner_active  = !early && (cmd != hsq_pkg::CMD_DISABLE);
		res.planner_restart = prst;
	end

	// Homing state, updated once per accepted tick.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_cmd_q  <= hsq_pkg::CMD_DISABLE;
			step_q      <= hsq_pkg::STEP_INIT;
			speed_q     <= '0;
			accel_q     <= '0;
			status_q    <= hsq_pkg::HS_IDLE;
			idx_latch_q <= 1'b0;
			meth_q      <= METH_NONE;
			sw_spd_q    <= '0;
			idx_spd_q   <= '0;
		end else if (fire) begin
			prev_cmd_q  <= prev_cmd_d;
			step_q      <= step_d;
			speed_q     <= speed_d;
			accel_q     <= accel_d;
			status_q    <= status_d;
			idx_latch_q <= idx_latch_d;
			meth_q      <= meth_d;
			sw_spd_q    <= sw_spd_d;
			idx_spd_q   <= idx_spd_d;
		end
	end

endmodule

>>> rtl/servo_homing_sequencer.sv
// ----------------------------------------------------------------------------
// Servo homing sequencer
// Homing step machine for a servo drive, one control tick per beat.
// ----------------------------------------------------------------------------
// Usage:
//   tick   : valid/ready channel, one beat per control tick carrying the drive
//            command, switch and index inputs and the actual position.
//   result : valid/ready channel, exactly one beat for every tick beat, with
//            target speed and acceleration, homing step and status, the
//            one-shot home position and the planner and disable requests.
//   cfg_*  : write port for the homing registers; write only while idle.
// Path: a taken tick is held in the tick register; its result is worked out
//   combinationally and held in the result register until it is taken.
// Throughput: one tick per cycle while results are taken; the homing state
//   lives in one register stage between the tick and result registers.
// Reset: registers return to their reset values, no beat is pending and
//   the step machine is at init with status idle.
// Stall: while result is not taken the result holds; the tick register
//   then fills and tick.ready drops until the result moves on.
// ----------------------------------------------------------------------------
module servo_homing_sequencer (
	input  logic                           clk,
	input  logic                           arst_n,
	hsq_tick_if.sink                       tick,
	hsq_result_if.source                   result,
	input  logic                           cfg_wr_en,
	input  logic [2:0]                     cfg_index,
	input  logic [hsq_pkg::CFG_DATA_W-1:0] cfg_wdata
);

	hsq_pkg::cfg_t    cfg;
	hsq_pkg::tick_t   tick_s1;
	logic             tick_vld_s1;
	hsq_pkg::result_t res_comb;
	hsq_pkg::result_t res_s2;
	logic             res_vld_s2;
	logic             out_free;
	logic             fire;

	hsq_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_wr_en),
		.wr_index (cfg_index),
		.wr_data  (cfg_wdata),
		.cfg      (cfg)
	);

	hsq_step_unit u_step (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.fire   (fire),
		.tick   (tick_s1),
		.res    (res_comb)
	);

	// Handshake: the tick register moves on when the result register frees.
	assign out_free   = !res_vld_s2 || result.ready;
	assign fire       = tick_vld_s1 && out_free;
	assign tick.ready = !tick_vld_s1 || fire;

	// Valid flags of both stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_vld_s1 <= 1'b0;
			res_vld_s2  <= 1'b0;
		end else begin
			if (tick.ready) begin
				tick_vld_s1 <= tick.valid;
			end
			if (out_free) begin
				res_vld_s2 <= fire;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (tick.valid && tick.ready) begin
			tick_s1 <= tick.data;
		end
		if (fire) begin
			res_s2 <= res_comb;
		end
	end

	assign result.valid = res_vld_s2;
	assign result.data  = res_s2;

endmodule

>>> rtl/hsq_checker.sv
// ----------------------------------------------------------------------------
// Servo homing sequencer checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "servo_homing_sequencer_assert.svh"

module hsq_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             res_valid,
	input logic             res_ready,
	input hsq_pkg::result_t res_data
);

	// A home position is only reported on the tick that homing succeeds.
	`HSQ_ASSERT_IMPL(a_offset_on_success, res_valid && res_data.offset_valid, res_data.homing_status == hsq_pkg::HS_OK && res_data.homing_step == hsq_pkg::STEP_DONE, "home offset without successful homing")

	// The home position reads zero when no offset is reported.
	`HSQ_ASSERT_IMPL(a_home_pos_quiet, res_valid && !res_data.offset_valid, res_data.home_position == 32'sd0, "home position set without offset valid")

	// A planner restart comes with a running planner and no disable request.
	`HSQ_ASSERT_IMPL(a_restart_runs, res_valid && res_data.planner_restart, res_data.planner_active && !res_data.force_disable, "planner restart without active planner")

	// A stalled result beat stays valid and unchanged.
	`HSQ_ASSERT_NEXT(a_result_hold, res_valid && !res_ready, res_valid && $stable(res_data), "stalled result beat changed")

endmodule

bind servo_homing_sequencer hsq_checker u_hsq_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (result.valid),
	.res_ready (result.ready),
	.res_data  (result.data)
);

>>> dv/servo_homing_sequencer_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Servo homing sequencer testbench
// Drives control ticks into the sequencer and checks every result beat
// against a cycle-free model of the homing step machine. A short table of
// directed ticks covers the method codes, the switch and index search, the
// index latch, quick stop handling and the wrap of the home position. Random
// segments with fresh register settings follow, under three idling patterns.
// ----------------------------------------------------------------------------
module servo_homing_sequencer_tb;
	import hsq_pkg::*;

	localparam int CYCLE_LIMIT = 300000;

	// Bit positions of the one-bit tick inputs, in tick_t order.
	localparam logic [7:0] F_EMER = 8'h80;
	localparam logic [7:0] F_HALT = 8'h40;
	localparam logic [7:0] F_BRK  = 8'h20;
	localparam logic [7:0] F_PL   = 8'h10;
	localparam logic [7:0] F_NL   = 8'h08;
	localparam logic [7:0] F_HS   = 8'h04;
	localparam logic [7:0] F_IDX  = 8'h02;
	localparam logic [7:0] F_VZ   = 8'h01;

	// One row of the directed table: a register write or a tick.
	typedef struct {
		bit         is_cfg;
		cfg_idx_t   idx;
		logic [31:0] val;
		tick_t      t;
		bit         typed;
		result_t    want;
	} plan_row_t;

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	logic [2:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	hsq_tick_if   tick_ch ();
	hsq_result_if result_ch ();

	servo_homing_sequencer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.tick      (tick_ch),
		.result    (result_ch),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	// Register copies seen by the model.
	logic [6:0]  m_method;
	logic [30:0] m_sw_speed, m_idx_speed, m_accel, m_qs_decel, m_prof_decel;
	logic [3:0]  m_qs_opt;
	logic [31:0] m_offset;

	// Homing state of the model.
	logic [1:0]  h_prev_cmd;
	step_t       h_step;
	logic [31:0] h_speed;
	logic [30:0] h_accel;
	hstat_t      h_status;
	logic        h_idx_latch;
	logic [6:0]  h_method;
	logic [30:0] h_sw_speed, h_idx_speed;

	result_t   due_outputs[$];
	plan_row_t plan[$];
	int        mismatches = 0;
	int        cycles = 0;
	int        src_idle_pct = 10;
	int        rcv_stall_pct = 67;

	// Work out the result of one control tick and advance the homing state.
	function automatic result_t next_homing_outputs(input tick_t t);
		result_t    r;
		logic [1:0] cmd;
		bit         early;
		bit         seen;
		r = '0;
		early = 1'b0;
		cmd = (t.drive_command == CMD_RESERVED) ? CMD_DISABLE : t.drive_command;

		if (cmd == CMD_ENABLE && !t.emergency_requested) begin
			// A rising edge to enable latches the method and restarts the steps.
			if (h_prev_cmd == CMD_DISABLE) begin
				if (m_method == HM_NONE || m_method == HM_SWITCH_INDEX ||
				    m_method == HM_AT_POSITION) begin
					h_method = m_method;
					h_step = STEP_START;
					h_sw_speed = m_sw_speed;
					h_idx_speed = m_idx_speed;
					h_accel = m_accel;
					h_idx_latch = 1'b0;
					h_status = HS_IDLE;
					r.planner_restart = 1'b1;
				end else begin
					h_method = HM_NONE;
					h_step = STEP_FAIL;
					r.force_disable = 1'b1;
					early = 1'b1;
				end
			end
			if (!early) begin
				h_idx_latch = h_idx_latch | t.index_pulse;
				if (t.halt || !t.brake_released) begin
					h_speed = '0;
				end else if (h_step != STEP_DONE) begin
					seen = h_idx_latch;
					h_idx_latch = 1'b0;
					if (h_method == HM_SWITCH_INDEX) begin
						// Switch and index search.
						case (h_step)
							STEP_INIT: ;
							STEP_START: begin
								if (t.positive_limit && !t.home_sensor) begin
									h_speed = 32'd0 - {1'b0, h_sw_speed};
									h_step = STEP_SEEK_HOME;
								end else if (t.home_sensor) begin
									h_speed = 32'd0 - {1'b0, h_sw_speed};
									h_step = STEP_RETRACT;
								end else begin
									h_speed = {1'b0, h_sw_speed};
									h_step = STEP_SEEK_SW;
								end
							end
							STEP_SEEK_SW: begin
								if (t.home_sensor) begin
									h_speed = 32'd0 - {1'b0, h_sw_speed};
									h_step = STEP_RETRACT;
								end else if (t.positive_limit) begin
									h_speed = 32'd0 - {1'b0, h_sw_speed};
									h_step = STEP_SEEK_HOME;
								end else if (t.negative_limit) begin
									h_speed = '0;
									h_step = STEP_FAIL;
								end
							end
							STEP_SEEK_HOME: begin
								if (t.home_sensor) begin
									h_speed = 32'd0 - {1'b0, h_sw_speed};
									h_step = STEP_RETRACT;
								end else if (t.negative_limit) begin
									h_speed = '0;
									h_step = STEP_FAIL;
								end
							end
							STEP_RETRACT: begin
								if (!t.home_sensor) begin
									h_speed = 32'd0 - {1'b0, h_idx_speed};
									h_step = STEP_SEEK_IDX;
								end
							end
							STEP_SEEK_IDX: begin
								if (seen) begin
									h_speed = '0;
									h_step = STEP_DECEL;
								end
							end
							STEP_DECEL: begin
								if (t.standstill) begin
									h_speed = '0;
									h_step = STEP_DONE;
								end
							end
							STEP_DONE: h_speed = '0;
							default: begin
								h_speed = '0;
								h_step = STEP_FAIL;
							end
						endcase
					end else if (h_method == HM_AT_POSITION) begin
						h_speed = '0;
						h_step = STEP_DONE;
					end else begin
						h_step = STEP_FAIL;
					end
				end
				// Success is reported once, with the offset position.
				if (h_step == STEP_DONE && h_status != HS_OK) begin
					h_status = HS_OK;
					r.offset_valid = 1'b1;
					r.home_position = t.actual_position + m_offset;
				end else if (h_step == STEP_FAIL) begin
					h_status = HS_FAIL;
				end
			end
		end else begin
			h_idx_latch = h_idx_latch | t.index_pulse;
			if (cmd == CMD_ENABLE) begin
				cmd = CMD_DISABLE;
				r.force_disable = 1'b1;
			end
		end

		if (!early) begin
			// Emergency brake: fail, stop, and pick the deceleration.
			if (cmd == CMD_EBRAKE) begin
				h_step = STEP_FAIL;
				h_speed = '0;
				case (m_qs_opt)
					QSO_QUICK, QSO_CURRENT, QSO_QUICK_STAY, QSO_CURRENT_STAY:
						h_accel = m_qs_decel;
					QSO_DISABLE: ;
					default: h_accel = m_prof_decel;
				endcase
				if (m_qs_opt <= QSO_VOLTAGE && (m_qs_opt == QSO_DISABLE || t.standstill)) begin
					r.force_disable = 1'b1;
					cmd = CMD_DISABLE;
				end
			end
			r.planner_active = (cmd != CMD_DISABLE);
			h_prev_cmd = cmd;
		end

		r.target_speed = h_speed;
		r.target_accel = h_accel;
		r.homing_step = h_step;
		r.homing_status = h_status;
		return r;
	endfunction

	// Print one line for each mismatch and count it.
	task automatic report_mismatch(input string msg);
		mismatches++;
		$display("MISMATCH at cycle %0d: %s", cycles, msg);
	endtask

	// Append a directed tick.
	task automatic add_tick(input logic [1:0] cmd, input logic [7:0] flags,
	                        input logic [31:0] pos);
		plan_row_t row;
		row.is_cfg = 1'b0;
		row.idx = CFG_HOME_MODE;
		row.val = '0;
		row.t = tick_t'({cmd, flags, pos});
		row.typed = 1'b0;
		row.want = '0;
		plan.push_back(row);
	endtask

	// Append a directed register write.
	task automatic add_cfg(input cfg_idx_t idx, input logic [31:0] val);
		plan_row_t row;
		row.is_cfg = 1'b1;
		row.idx = idx;
		row.val = val;
		row.t = '0;
		row.typed = 1'b0;
		row.want = '0;
		plan.push_back(row);
	endtask

	// Pin the result of the last directed tick to a typed-in value.
	task automatic add_want(input result_t want);
		plan[$].typed = 1'b1;
		plan[$].want = want;
	endtask

	// Called at a falling edge; returns at a falling edge once every beat is back.
	task automatic wait_idle();
		tick_ch.valid <= 1'b0;
		while (due_outputs.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// Write one register while the block is idle.
	task automatic write_reg(input cfg_idx_t idx, input logic [31:0] val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		case (idx)
			CFG_HOME_MODE:     m_method = val[6:0];
			CFG_SWITCH_SPEED:  m_sw_speed = val[30:0];
			CFG_INDEX_SPEED:   m_idx_speed = val[30:0];
			CFG_HOMING_ACCEL:  m_accel = val[30:0];
			CFG_QS_DECEL:      m_qs_decel = val[30:0];
			CFG_PROFILE_DECEL: m_prof_decel = val[30:0];
			CFG_QS_OPTION:     m_qs_opt = val[3:0];
			CFG_HOME_OFFSET:   m_offset = val;
			default: ;
		endcase
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		@(negedge clk);
	endtask

	// Called at a falling edge; offers one tick and returns after its beat.
	task automatic send_tick(input tick_t t, input bit typed, input result_t want);
		result_t predicted;
		while ($urandom_range(0, 99) < src_idle_pct) begin
			tick_ch.valid <= 1'b0;
			@(negedge clk);
		end
		tick_ch.valid <= 1'b1;
		tick_ch.data <= t;
		@(posedge clk);
		while (!tick_ch.ready)
			@(posedge clk);
		predicted = next_homing_outputs(t);
		due_outputs.push_back(typed ? want : predicted);
		@(negedge clk);
	endtask

	// Clock and cycle limit.
	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("servo_homing_sequencer_tb NOT OK");
			$finish;
		end
	end

	// Result side: random stalls, driven at the falling edge.
	always @(negedge clk) begin
		result_ch.ready <= ($urandom_range(0, 99) >= rcv_stall_pct);
	end

	// Compare each result beat with the oldest expectation.
	always @(posedge clk) begin
		result_t got;
		result_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			got = result_ch.data;
			if (due_outputs.size() == 0) begin
				report_mismatch("result beat with nothing expected");
			end else begin
				want = due_outputs.pop_front();
				if (got.target_speed !== want.target_speed)
					report_mismatch($sformatf("target_speed %0d, expected %0d",
						got.target_speed, want.target_speed));
				if (got.target_accel !== want.target_accel)
					report_mismatch($sformatf("target_accel %0d, expected %0d",
						got.target_accel, want.target_accel));
				if (got.homing_step !== want.homing_step)
					report_mismatch($sformatf("homing_step %0d, expected %0d",
						got.homing_step, want.homing_step));
				if (got.homing_status !== want.homing_status)
					report_mismatch($sformatf("homing_status %0d, expected %0d",
						got.homing_status, want.homing_status));
				if (got.offset_valid !== want.offset_valid)
					report_mismatch($sformatf("offset_valid %0b, expected %0b",
						got.offset_valid, want.offset_valid));
				if (got.home_position !== want.home_position)
					report_mismatch($sformatf("home_position %0d, expected %0d",
						got.home_position, want.home_position));
				if (got.force_disable !== want.force_disable)
					report_mismatch($sformatf("force_disable %0b, expected %0b",
						got.force_disable, want.force_disable));
				if (got.planner_active !== want.planner_active)
					report_mismatch($sformatf("planner_active %0b, expected %0b",
						got.planner_active, want.planner_active));
				if (got.planner_restart !== want.planner_restart)
					report_mismatch($sformatf("planner_restart %0b, expected %0b",
						got.planner_restart, want.planner_restart));
			end
		end
	end

	initial begin
		logic [1:0]  cmd;
		logic [7:0]  flags;
		logic [31:0] pos;
		logic [31:0] val;
		logic [6:0]  method;
		int          roll;
		result_t     none;

		clk = 1'b0;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		tick_ch.valid = 1'b0;
		tick_ch.data = '0;
		result_ch.ready = 1'b0;
		none = '0;

		// Model state after reset.
		m_method = HM_NONE;
		m_sw_speed = '0;
		m_idx_speed = '0;
		m_accel = '0;
		m_qs_decel = '0;
		m_prof_decel = '0;
		m_qs_opt = QSO_DISABLE;
		m_offset = '0;
		h_prev_cmd = CMD_DISABLE;
		h_step = STEP_INIT;
		h_speed = '0;
		h_accel = '0;
		h_status = HS_IDLE;
		h_idx_latch = 1'b0;
		h_method = HM_NONE;
		h_sw_speed = '0;
		h_idx_speed = '0;

		// Directed table. No method and an invalid method first.
		add_tick(CMD_DISABLE, 8'h00, 32'd0);
		add_want('{target_speed: '0, target_accel: '0, homing_step: STEP_INIT,
			homing_status: HS_IDLE, offset_valid: 1'b0, home_position: '0,
			force_disable: 1'b0, planner_active: 1'b0, planner_restart: 1'b0});
		add_tick(CMD_ENABLE, F_BRK, 32'd0);
		add_want('{target_speed: '0, target_accel: '0, homing_step: STEP_FAIL,
			homing_status: HS_FAIL, offset_valid: 1'b0, home_position: '0,
			force_disable: 1'b0, planner_active: 1'b1, planner_restart: 1'b1});
		add_tick(CMD_DISABLE, 8'h00, 32'd0);
		add_cfg(CFG_HOME_MODE, 32'h7F);
		add_tick(CMD_ENABLE, F_BRK, 32'd0);
		add_want('{target_speed: '0, target_accel: '0, homing_step: STEP_FAIL,
			homing_status: HS_FAIL, offset_valid: 1'b0, home_position: '0,
			force_disable: 1'b1, planner_active: 1'b0, planner_restart: 1'b0});
		add_tick(CMD_DISABLE, 8'h00, 32'd0);

		// Home at the current position, with the offset wrapping.
		add_cfg(CFG_HOME_MODE, 32'(HM_AT_POSITION));
		add_cfg(CFG_HOMING_ACCEL, 32'h7FFF_FFFF);
		add_cfg(CFG_HOME_OFFSET, 32'h7FFF_FFFF);
		add_tick(CMD_ENABLE, F_BRK, 32'd1);
		add_want('{target_speed: '0, target_accel: 31'h7FFF_FFFF, homing_step: STEP_DONE,
			homing_status: HS_OK, offset_valid: 1'b1, home_position: 32'h8000_0000,
			force_disable: 1'b0, planner_active: 1'b1, planner_restart: 1'b1});
		add_tick(CMD_ENABLE, F_BRK, 32'd5);
		add_tick(CMD_EBRAKE, F_VZ, 32'd0);

		// Full switch and index search, with halts, brake and the index latch.
		add_cfg(CFG_HOME_MODE, 32'(HM_SWITCH_INDEX));
		add_cfg(CFG_SWITCH_SPEED, 32'h7FFF_FFFF);
		add_cfg(CFG_INDEX_SPEED, 32'd1);
		add_cfg(CFG_HOME_OFFSET, 32'h8000_0000);
		add_cfg(CFG_QS_OPTION, 32'(QSO_QUICK));
		add_cfg(CFG_QS_DECEL, 32'd5);
		add_cfg(CFG_PROFILE_DECEL, 32'd9);
		add_tick(CMD_DISABLE, 8'h00, 32'd0);
		add_tick(CMD_ENABLE, F_BRK, 32'd0);
		add_tick(CMD_ENABLE, F_BRK | F_HALT, 32'd0);
		add_tick(CMD_ENABLE, F_BRK | F_PL, 32'd0);
		add_tick(CMD_ENABLE, F_IDX, 32'd0);
		add_tick(CMD_ENABLE, F_BRK, 32'd0);
		add_tick(CMD_ENABLE, F_BRK | F_HS, 32'd0);
		add_tick(CMD_ENABLE, F_BRK | F_HALT | F_IDX | F_HS, 32'd0);
		add_tick(CMD_ENABLE, F_BRK, 32'd0);
		add_tick(CMD_ENABLE, F_BRK | F_HALT | F_IDX, 32'd0);
		add_tick(CMD_ENABLE, F_BRK, 32'd0);
		add_tick(CMD_ENABLE, F_BRK | F_VZ, 32'h7FFF_FFFF);
		add_want('{target_speed: '0, target_accel: 31'h7FFF_FFFF, homing_step: STEP_DONE,
			homing_status: HS_OK, offset_valid: 1'b1, home_position: 32'hFFFF_FFFF,
			force_disable: 1'b0, planner_active: 1'b1, planner_restart: 1'b0});

		// Emergency request, emergency brake, the reserved command, limit failure.
		add_tick(CMD_ENABLE, F_BRK | F_EMER, 32'd0);
		add_tick(CMD_ENABLE, F_BRK, 32'd0);
		add_tick(CMD_EBRAKE, F_BRK, 32'd0);
		add_tick(CMD_EBRAKE, F_BRK | F_VZ, 32'd0);
		add_tick(CMD_RESERVED, F_BRK, 32'h8000_0000);
		add_tick(CMD_ENABLE, F_BRK, 32'd0);
		add_tick(CMD_ENABLE, F_BRK | F_NL, 32'd0);

		// Hold reset, then release it at a falling edge.
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (plan[i]) begin
			if (plan[i].is_cfg) begin
				wait_idle();
				write_reg(plan[i].idx, plan[i].val);
			end else begin
				send_tick(plan[i].t, plan[i].typed, plan[i].want);
			end
		end

		// Random segments under three idling patterns, fresh registers each time.
		for (int phase = 0; phase < 3; phase++) begin
			src_idle_pct = (phase == 0) ? 10 : (phase == 1) ? 67 : 0;
			rcv_stall_pct = (phase == 0) ? 67 : (phase == 1) ? 10 : 0;
			for (int seg = 0; seg < 5; seg++) begin
				wait_idle();
				case ($urandom_range(0, 19))
					0, 1: method = HM_NONE;
					2, 3, 4: method = HM_AT_POSITION;
					5, 6: method = 7'($urandom_range(0, 127));
					default: method = HM_SWITCH_INDEX;
				endcase
				write_reg(CFG_HOME_MODE, ($urandom & ~32'h7F) | {25'd0, method});
				for (int r = 1; r < 8; r++) begin
					case ($urandom_range(0, 5))
						0: val = 32'h0000_0000;
						1: val = 32'hFFFF_FFFF;
						2: val = 32'h7FFF_FFFF;
						3: val = 32'h8000_0000;
						default: val = $urandom;
					endcase
					write_reg(cfg_idx_t'(r), val);
				end

				for (int n = 0; n < 100; n++) begin
					// Mostly enabled with the brake released, so homing runs deep.
					roll = $urandom_range(0, 99);
					cmd = (roll < 82) ? CMD_ENABLE : (roll < 88) ? CMD_DISABLE :
						(roll < 95) ? CMD_EBRAKE : CMD_RESERVED;
					flags = '0;
					if ($urandom_range(0, 29) == 0) flags |= F_EMER;
					if ($urandom_range(0, 11) == 0) flags |= F_HALT;
					if ($urandom_range(0, 14) != 0) flags |= F_BRK;
					if ($urandom_range(0, 5) == 0)  flags |= F_PL;
					if ($urandom_range(0, 11) == 0) flags |= F_NL;
					if ($urandom_range(0, 3) == 0)  flags |= F_HS;
					if ($urandom_range(0, 5) == 0)  flags |= F_IDX;
					if ($urandom_range(0, 2) == 0)  flags |= F_VZ;
					case ($urandom_range(0, 9))
						0: pos = 32'h7FFF_FFFF;
						1: pos = 32'h8000_0000;
						default: pos = $urandom;
					endcase
					send_tick(tick_t'({cmd, flags, pos}), 1'b0, none);
				end
			end
		end

		// Drain, then settle before the verdict.
		wait_idle();
		repeat (8) @(negedge clk);
		if (mismatches == 0)
			$display("servo_homing_sequencer_tb OK");
		else
			$display("servo_homing_sequencer_tb NOT OK");
		$finish;
	end

endmodule
